FILE: hdl/rtpm_pkg.sv
// Package for the IPv4 route table with longest-prefix ordering.
// Holds sizes, operation/status/register codes, the route entry type and the
// prefix length helper. No dependencies.
`timescale 1ns / 1ps

package rtpm_pkg;

  // Table geometry
  localparam int ROUTE_DEPTH = 16;
  localparam int IDX_W       = $clog2(ROUTE_DEPTH);
  localparam int CNT_W       = $clog2(ROUTE_DEPTH + 1);
  localparam int LEN_W       = 6;
  localparam int CFG_AW      = 4;

  // Operation codes carried on in_tuser
  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_DELETE = 2'd2
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2,
    STAT_PROT = 2'd3
  } status_t;

  // Configuration register indexes (paddr[3:2])
  typedef enum logic [1:0] {
    REG_IF0_ADDR = 2'd0,
    REG_IF0_MASK = 2'd1,
    REG_IF1_ADDR = 2'd2,
    REG_IF1_MASK = 2'd3
  } cfg_reg_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_ADD_SCAN,
    S_ADD_HEAD,
    S_DEL_FIND,
    S_DEL_SHIFT,
    S_DONE
  } state_t;

  // Interface settings handed from the register block to the controller
  typedef struct packed {
    logic [31:0] if0_addr;
    logic [31:0] if0_mask;
    logic [31:0] if1_addr;
    logic [31:0] if1_mask;
  } iface_cfg_t;

  // One user route as stored in the table memory
  typedef struct packed {
    logic [31:0] gateway;
    logic [31:0] mask;
    logic [31:0] network;
  } route_entry_t;

  // Number of leading one bits of a mask, counted from the MSB
  function automatic logic [LEN_W-1:0] leading_ones(input logic [31:0] m);
    logic [LEN_W-1:0] n;
    n = LEN_W'(32);
    for (int i = 0; i < 32; i++) begin
      if (!m[i]) begin
        n = LEN_W'(31 - i);
      end
    end
    return n;
  endfunction

endpackage

FILE: hdl/rtpm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module rtpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/rtpm_cfg.sv
// APB-style register block for the two interface address/netmask pairs.
// Depends on rtpm_pkg.
`timescale 1ns / 1ps

module rtpm_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [rtpm_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready,
  output rtpm_pkg::iface_cfg_t      iface
);

  import rtpm_pkg::*;

  iface_cfg_t iface_r, iface_nxt;
  cfg_reg_t   sel;
  logic       wr;

  assign sel        = cfg_reg_t'(cfg_paddr[3:2]);
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  // Register write decode
  always_comb begin
    iface_nxt = iface_r;
    if (wr) begin
      case (sel)
        REG_IF0_ADDR: iface_nxt.if0_addr = cfg_pwdata;
        REG_IF0_MASK: iface_nxt.if0_mask = cfg_pwdata;
        REG_IF1_ADDR: iface_nxt.if1_addr = cfg_pwdata;
        REG_IF1_MASK: iface_nxt.if1_mask = cfg_pwdata;
        default:      iface_nxt = iface_r;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (sel)
      REG_IF0_ADDR: cfg_prdata = iface_r.if0_addr;
      REG_IF0_MASK: cfg_prdata = iface_r.if0_mask;
      REG_IF1_ADDR: cfg_prdata = iface_r.if1_addr;
      REG_IF1_MASK: cfg_prdata = iface_r.if1_mask;
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iface_r <= '0;
    end else begin
      iface_r <= iface_nxt;
    end
  end

  assign iface = iface_r;

endmodule

FILE: hdl/rtpm_ctrl.sv
// Sequencer for lookup, add and delete: walks the route memory one entry a
// cycle, shifts entries on insert/remove and keeps the route count.
// Depends on rtpm_pkg; drives one rtpm_ram instance through its ports.
`timescale 1ns / 1ps

module rtpm_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rtpm_pkg::iface_cfg_t         iface,
  // operation in
  input  logic                         op_valid,
  output logic                         op_ready,
  input  logic [1:0]                   op_kind,
  input  logic [31:0]                  op_address,
  input  logic [31:0]                  op_mask,
  input  logic [31:0]                  op_gateway,
  // result out
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [1:0]                   res_status,
  output logic [31:0]                  res_next_hop,
  // route memory
  output logic                         mem_we,
  output logic [rtpm_pkg::IDX_W-1:0]   mem_waddr,
  output rtpm_pkg::route_entry_t       mem_wdata,
  output logic [rtpm_pkg::IDX_W-1:0]   mem_raddr,
  input  rtpm_pkg::route_entry_t       mem_rdata
);

  import rtpm_pkg::*;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [31:0]        addr_r, addr_nxt;
  logic [31:0]        mask_r, mask_nxt;
  logic [31:0]        gw_r, gw_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  status_t            rstat_r, rstat_nxt;
  logic [31:0]        rhop_r, rhop_nxt;
  logic               oval_r, oval_nxt;
  status_t            ostat_r, ostat_nxt;
  logic [31:0]        ohop_r, ohop_nxt;

  kind_t              kind;
  logic               accept;
  logic               empty, full;
  logic               dir_lookup, dir_delete;
  logic [31:0]        net0, net1;
  logic [CNT_W-1:0]   last_idx;
  logic               at_last, at_head;
  logic               hit_route, hit_net, add_stop;
  logic               out_free;
  route_entry_t       new_entry;

  // Shared conditions
  assign kind       = kind_t'(op_kind);
  assign op_ready   = (state_r == S_IDLE);
  assign accept     = op_valid & op_ready;
  assign empty      = (count_r == '0);
  assign full       = (count_r == CNT_W'(ROUTE_DEPTH));
  assign net0       = iface.if0_addr & iface.if0_mask;
  assign net1       = iface.if1_addr & iface.if1_mask;
  assign dir_lookup = ((op_address & iface.if1_mask) == net1) ||
                      ((op_address & iface.if0_mask) == net0);
  assign dir_delete = (op_address == net1) || (op_address == net0);
  assign last_idx   = count_r - CNT_W'(1);
  assign at_last    = (CNT_W'(idx_r) == last_idx);
  assign at_head    = (idx_r == '0);
  assign hit_route  = ((mem_rdata.mask & addr_r) == mem_rdata.network);
  assign hit_net    = (mem_rdata.network == addr_r);
  assign add_stop   = (leading_ones(mem_rdata.mask) > len_r);
  assign out_free   = !oval_r || res_ready;
  assign new_entry  = '{gateway: gw_r, mask: mask_r, network: addr_r};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_LOOKUP: state_nxt = (dir_lookup || empty) ? S_DONE : S_LOOKUP;
            KIND_ADD:    state_nxt = full ? S_DONE : (empty ? S_ADD_HEAD : S_ADD_SCAN);
            KIND_DELETE: state_nxt = (dir_delete || empty) ? S_DONE : S_DEL_FIND;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_LOOKUP: begin
        if (hit_route || at_last) state_nxt = S_DONE;
      end
      S_ADD_SCAN: begin
        if (add_stop) begin
          state_nxt = S_DONE;
        end else if (at_head) begin
          state_nxt = S_ADD_HEAD;
        end
      end
      S_ADD_HEAD: state_nxt = S_DONE;
      S_DEL_FIND: begin
        if (at_last) begin
          state_nxt = S_DONE;
        end else if (hit_net) begin
          state_nxt = S_DEL_SHIFT;
        end
      end
      S_DEL_SHIFT: begin
        if (at_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    idx_nxt   = idx_r;
    count_nxt = count_r;
    addr_nxt  = addr_r;
    mask_nxt  = mask_r;
    gw_nxt    = gw_r;
    len_nxt   = len_r;
    rstat_nxt = rstat_r;
    rhop_nxt  = rhop_r;
    oval_nxt  = res_ready ? 1'b0 : oval_r;
    ostat_nxt = ostat_r;
    ohop_nxt  = ohop_r;
    mem_we    = 1'b0;
    mem_waddr = idx_r + IDX_W'(1);
    mem_wdata = mem_rdata;
    mem_raddr = idx_r + IDX_W'(1);

    case (state_r)
      S_IDLE: begin
        // adds scan from the tail, everything else from the head
        mem_raddr = (kind == KIND_ADD) ? last_idx[IDX_W-1:0] : '0;
        if (accept) begin
          addr_nxt = op_address;
          mask_nxt = op_mask;
          gw_nxt   = op_gateway;
          len_nxt  = leading_ones(op_mask);
          idx_nxt  = (kind == KIND_ADD) ? last_idx[IDX_W-1:0] : '0;
          rhop_nxt = '0;
          case (kind)
            KIND_LOOKUP: rstat_nxt = dir_lookup ? STAT_OK : STAT_MISS;
            KIND_ADD:    rstat_nxt = STAT_FULL;
            KIND_DELETE: rstat_nxt = dir_delete ? STAT_PROT : STAT_MISS;
            default:     rstat_nxt = STAT_MISS;
          endcase
        end
      end
      S_LOOKUP: begin
        if (hit_route) begin
          rstat_nxt = STAT_OK;
          rhop_nxt  = mem_rdata.gateway;
        end else if (at_last) begin
          rstat_nxt = STAT_MISS;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_ADD_SCAN: begin
        // move shorter-or-equal prefixes down one slot; stop above a longer one
        mem_raddr = idx_r - IDX_W'(1);
        mem_we    = 1'b1;
        mem_waddr = idx_r + IDX_W'(1);
        if (add_stop) begin
          mem_wdata = new_entry;
          count_nxt = count_r + CNT_W'(1);
          rstat_nxt = STAT_OK;
        end else begin
          idx_nxt = idx_r - IDX_W'(1);
        end
      end
      S_ADD_HEAD: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = new_entry;
        count_nxt = count_r + CNT_W'(1);
        rstat_nxt = STAT_OK;
      end
      S_DEL_FIND: begin
        if (hit_net && at_last) begin
          count_nxt = count_r - CNT_W'(1);
          rstat_nxt = STAT_OK;
        end else if (at_last) begin
          rstat_nxt = STAT_MISS;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_DEL_SHIFT: begin
        // pull each later entry up one slot
        mem_we    = 1'b1;
        mem_waddr = idx_r - IDX_W'(1);
        if (at_last) begin
          count_nxt = count_r - CNT_W'(1);
          rstat_nxt = STAT_OK;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          oval_nxt  = 1'b1;
          ostat_nxt = rstat_r;
          ohop_nxt  = rhop_r;
        end
      end
      default: begin
        idx_nxt = idx_r;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      oval_r  <= oval_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    addr_r  <= addr_nxt;
    mask_r  <= mask_nxt;
    gw_r    <= gw_nxt;
    len_r   <= len_nxt;
    rstat_r <= rstat_nxt;
    rhop_r  <= rhop_nxt;
    ostat_r <= ostat_nxt;
    ohop_r  <= ohop_nxt;
  end

  assign res_valid    = oval_r;
  assign res_status   = ostat_r;
  assign res_next_hop = ohop_r;

endmodule

FILE: hdl/route_table_prefix_match.sv
// Top level of the IPv4 route table: stream ports, register port, route memory.
// Depends on rtpm_pkg, rtpm_ram, rtpm_cfg and rtpm_ctrl.
//
//  channel   direction  word contents
//  in_*      slave      tuser: kind; tdata: address, prefix_mask, gateway
//  out_*     master     tdata: status, next_hop (zero padded to 40 bits)
//  cfg_*     APB slave  4 x 32-bit interface address / netmask registers
//
// The walk over the route memory, one entry per cycle through its single
// read port, sets how long an item takes; at most ROUTE_DEPTH routes are
// held. Direct routes, a full table and lookups or deletes on an empty
// table finish without a walk, and an add to an empty table writes the head
// entry first. Reset clears control and the route count; memory contents
// are not cleared, only entries below the count are read.
// A finished result sits in the output register, and the next word is taken
// once the previous result has moved there.
`timescale 1ns / 1ps

module route_table_prefix_match (
  input  logic                        clk,
  input  logic                        rst_n,
  // input words
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [95:0]                 in_tdata,   // address, prefix_mask, gateway
  input  logic [1:0]                  in_tuser,   // kind
  // result words
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [39:0]                 out_tdata,  // status, next_hop, zero pad
  // register port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [rtpm_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  import rtpm_pkg::*;

  iface_cfg_t          iface;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [IDX_W-1:0]    mem_raddr;
  route_entry_t        mem_wdata;
  route_entry_t        mem_rdata;
  logic [1:0]          res_status;
  logic [31:0]         res_next_hop;

  // Interface registers
  rtpm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .iface       (iface)
  );

  // Route table memory
  rtpm_ram #(
    .WIDTH ($bits(route_entry_t)),
    .DEPTH (ROUTE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Operation sequencer
  rtpm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .iface        (iface),
    .op_valid     (in_tvalid),
    .op_ready     (in_tready),
    .op_kind      (in_tuser),
    .op_address   (in_tdata[31:0]),
    .op_mask      (in_tdata[63:32]),
    .op_gateway   (in_tdata[95:64]),
    .res_valid    (out_tvalid),
    .res_ready    (out_tready),
    .res_status   (res_status),
    .res_next_hop (res_next_hop),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  // Result word packing
  assign out_tdata = {6'd0, res_next_hop, res_status};

endmodule
